// ===== hdl/vrbc_pkg.sv =====
// Shared widths and types for the value rank-by-count block.
`default_nettype none
package vrbc_pkg;

  // Width of one input value, two's complement.
  localparam int VALUE_W = 32;

  // Width of the rank field on the result side.
  localparam int RANK_W = 6;

  // Result tdata is the rank padded up to a whole byte.
  localparam int OUT_TDATA_W = 8;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [RANK_W-1:0] rank_t;

endpackage
`default_nettype wire

// ===== hdl/vrbc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module vrbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/value_rank_by_count_top.sv =====
// Top level of the value rank-by-count block: store, sequencer and shared comparator.
// Values are taken one item per cycle until the final one; then each stored value is
// ranked in turn: one memory read for the pivot, then one sweep of reads over all stored
// values through the single read port and the single comparator, and then the result
// item waits for m_tready.
// Reset (rst, synchronous, active high) clears the sequencer, the fill count and the
// drop flag; the value memory is not cleared and needs no clearing pass.
`default_nettype none
module value_rank_by_count_top #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input items.
  input  wire logic                                s_tvalid,
  output      logic                                s_tready,
  input  wire logic [vrbc_pkg::VALUE_W-1:0]         s_tdata,   // [31:0] value
  input  wire logic                                s_tlast,   // final_value
  // Result items.
  output      logic                                m_tvalid,
  input  wire logic                                m_tready,
  output      logic [vrbc_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [5:0] rank, [7:6] zero
  output      logic                                m_tlast,   // final_rank
  output      logic                                m_tuser    // overflow
);
  import vrbc_pkg::*;

  // Address width of the store and width of a count that can reach MAX_ITEMS.
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  // Width that holds both a rank count and the rank field, for clean truncation.
  localparam int KW = (AW > RANK_W) ? AW : RANK_W;

  // Sequencer states.
  localparam logic [2:0] S_IN    = 3'd0;  // taking values
  localparam logic [2:0] S_PIVOT = 3'd1;  // read the value being ranked
  localparam logic [2:0] S_LATCH = 3'd2;  // capture it, start the sweep
  localparam logic [2:0] S_SWEEP = 3'd3;  // compare against every stored value
  localparam logic [2:0] S_OUT   = 3'd4;  // result item waits to be taken

  logic [2:0]    state;
  logic [CW-1:0] stored_count;
  logic          dropped_flag;
  logic [AW-1:0] idx;          // element being ranked
  logic [CW-1:0] sweep;        // next address to read during the sweep
  logic [AW-1:0] cnt;          // smaller values found so far
  value_t        pivot;
  rank_t         rank;
  logic          final_rank;

  // Memory port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic          in_accept;
  logic          out_accept;
  logic          store_full;
  logic          smaller;
  logic [AW-1:0] cnt_sum;
  logic [KW-1:0] rank_wide;
  logic          last_elem;

  assign in_accept  = s_tvalid && s_tready;
  assign out_accept = m_tvalid && m_tready;
  assign store_full = (stored_count == CW'(MAX_ITEMS));

  // A value is written only while there is room; the final item still ends the set.
  assign ram_we    = in_accept && !store_full;
  assign ram_waddr = stored_count[AW-1:0];

  // The pivot read and the sweep reads share the one read port.
  always_comb begin
    case (state)
      S_PIVOT: ram_raddr = idx;
      S_LATCH: ram_raddr = '0;
      S_SWEEP: ram_raddr = sweep[AW-1:0];
      default: ram_raddr = idx;
    endcase
  end

  // The one shared comparator: does the stored value lie strictly below the pivot?
  assign smaller   = ($signed(ram_rdata) < pivot);
  assign cnt_sum   = cnt + AW'(smaller);
  assign rank_wide = KW'(cnt_sum);
  assign last_elem = ((CW'(idx) + CW'(1)) == stored_count);

  vrbc_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(s_tdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IN;
      stored_count <= '0;
      dropped_flag <= 1'b0;
      idx          <= '0;
      sweep        <= '0;
      cnt          <= '0;
    end else begin
      case (state)
        S_IN: begin
          if (in_accept) begin
            if (!store_full) begin
              stored_count <= stored_count + CW'(1);
            end else begin
              dropped_flag <= 1'b1;
            end
            if (s_tlast) begin
              idx   <= '0;
              state <= S_PIVOT;
            end
          end
        end
        S_PIVOT: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          // Read data now holds the element being ranked; address zero goes out.
          pivot <= ram_rdata;
          cnt   <= '0;
          sweep <= CW'(1);
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          // Read data holds the stored value at address sweep - 1.
          if (sweep == stored_count) begin
            rank       <= rank_wide[RANK_W-1:0];
            final_rank <= last_elem;
            state      <= S_OUT;
          end else begin
            cnt   <= cnt_sum;
            sweep <= sweep + CW'(1);
          end
        end
        S_OUT: begin
          if (out_accept) begin
            if (final_rank) begin
              // Set finished: the store starts over for the next set.
              stored_count <= '0;
              dropped_flag <= 1'b0;
              state        <= S_IN;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_PIVOT;
            end
          end
        end
        default: begin
          state <= S_IN;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IN);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = OUT_TDATA_W'(rank);
  assign m_tlast  = final_rank;
  assign m_tuser  = dropped_flag;

endmodule
`default_nettype wire

// ===== hdl/vrbc_checker.sv =====
// Port-level checker for the value rank-by-count block, bound to the top level.
`default_nettype none
module vrbc_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic [vrbc_pkg::VALUE_W-1:0]         s_tdata,
  input wire logic                                s_tlast,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [vrbc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input wire logic                                m_tlast,
  input wire logic                                m_tuser
);
  import vrbc_pkg::*;

  logic in_acc;
  logic out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Results are only shown while no new value is being taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("result shown while input is ready");

  // A non-final value leaves the block ready for the next one.
  a_keep_taking: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !s_tlast) |=> (s_tready && !m_tvalid))
    else $error("block stopped taking values before the final one");

  // The final value closes the input.
  a_close_on_final: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tlast) |=> !s_tready)
    else $error("input still open after the final value");

  // After the last rank the block returns to taking values.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (out_acc && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block did not reopen after the last rank");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind value_rank_by_count_top vrbc_checker u_vrbc_checker (.*);
`default_nettype wire
